### sv/mvs_pkg.sv
// Package for the memory value scanner: sizes, mode and result codes,
// configuration register indexes and the record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package mvs_pkg;

  // Window depth, which is also the longest pattern
  localparam int PATTERN_MAX = 16;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
  localparam int ADDR_BITS   = 48;

  // Page match count, saturating
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register widths
  localparam int PLEN_W    = 5;
  localparam int VALUE_W   = 32;
  localparam int PATWORD_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_HALF    = 2'd1,
    MODE_WORD    = 2'd2,
    MODE_PATTERN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_MATCH = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd4;

  // Work for the back end: one or two output beats
  typedef struct packed {
    logic                 has_match;
    logic [ADDR_BITS-1:0] match_addr;
    logic                 has_status;
    kind_t                status_kind;
    logic [COUNT_W-1:0]   count;
  } rec_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    rec_t rec;
  } qhead_t;

endpackage

### sv/mvs_front.sv
// Front end of the memory value scanner: configuration registers, byte
// window, page state and match detection. Pushes records into the queue.
// Depends on mvs_pkg.
`timescale 1ns / 1ps

module mvs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte_value,
  input  logic [mvs_pkg::ADDR_BITS-1:0]        in_byte_address,
  input  logic                                 in_page_end,
  input  logic                                 in_access_fault,
  input  logic                                 q_full,
  output logic                                 q_push,
  output mvs_pkg::rec_t                        q_rec
);

  // Configuration
  mvs_pkg::mode_t                      mode_r;
  logic [mvs_pkg::VALUE_W-1:0]         value_r;
  logic [mvs_pkg::PLEN_W-1:0]          plen_r;
  logic [mvs_pkg::PATWORD_W-1:0]       pat_lo_r;
  logic [mvs_pkg::PATWORD_W-1:0]       pat_hi_r;

  // Page state
  logic [7:0]                   win_r   [mvs_pkg::PATTERN_MAX];
  logic [7:0]                   win_nxt [mvs_pkg::PATTERN_MAX];
  logic [mvs_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic                         faulted_r, faulted_nxt;
  logic [mvs_pkg::COUNT_W-1:0]  count_r, count_nxt;

  logic [7:0]                   pat_b [mvs_pkg::PATTERN_MAX];
  logic [mvs_pkg::FILL_W-1:0]   eff_len;
  logic [mvs_pkg::FILL_W-1:0]   back;
  logic                         cond;
  logic                         pat_ok;
  logic                         hit;
  logic                         accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Pattern bytes, byte 0 in the low bits of the low word
  always_comb begin
    for (int j = 0; j < mvs_pkg::PATTERN_MAX; j++) begin
      if (j < 8) begin
        pat_b[j] = pat_lo_r[8*j +: 8];
      end else begin
        pat_b[j] = pat_hi_r[8*(j-8) +: 8];
      end
    end
  end

  // Window shift, fill and fault tracking
  always_comb begin
    win_nxt[0] = in_access_fault ? 8'd0 : in_byte_value;
    for (int i = 1; i < mvs_pkg::PATTERN_MAX; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    if (fill_r < mvs_pkg::FILL_W'(mvs_pkg::PATTERN_MAX)) begin
      fill_nxt = fill_r + 1'b1;
    end else begin
      fill_nxt = fill_r;
    end
    faulted_nxt = faulted_r || in_access_fault;
  end

  // Effective pattern length: zero means one, long values saturate
  always_comb begin
    if (plen_r == '0) begin
      eff_len = mvs_pkg::FILL_W'(1);
    end else if (32'(plen_r) > mvs_pkg::PATTERN_MAX) begin
      eff_len = mvs_pkg::FILL_W'(mvs_pkg::PATTERN_MAX);
    end else begin
      eff_len = mvs_pkg::FILL_W'(plen_r);
    end
  end

  // Pattern compare: pattern byte j against the window byte len-1-j
  always_comb begin
    logic [mvs_pkg::FILL_W-1:0] idx;
    pat_ok = 1'b1;
    idx    = '0;
    for (int j = 0; j < mvs_pkg::PATTERN_MAX; j++) begin
      idx = eff_len - mvs_pkg::FILL_W'(1) - mvs_pkg::FILL_W'(j);
      if (mvs_pkg::FILL_W'(j) < eff_len) begin
        if (win_nxt[idx[mvs_pkg::WIN_IDX_W-1:0]] != pat_b[j]) begin
          pat_ok = 1'b0;
        end
      end
    end
  end

  // Mode select
  always_comb begin
    case (mode_r)
      mvs_pkg::MODE_BYTE: begin
        back = '0;
        cond = (win_nxt[0] == value_r[7:0]);
      end
      mvs_pkg::MODE_HALF: begin
        back = mvs_pkg::FILL_W'(1);
        cond = in_byte_address[0] && (fill_nxt >= mvs_pkg::FILL_W'(2)) &&
               ({win_nxt[0], win_nxt[1]} == value_r[15:0]);
      end
      mvs_pkg::MODE_WORD: begin
        back = mvs_pkg::FILL_W'(3);
        cond = (in_byte_address[1:0] == 2'b11) &&
               (fill_nxt >= mvs_pkg::FILL_W'(4)) &&
               ({win_nxt[0], win_nxt[1], win_nxt[2], win_nxt[3]} == value_r);
      end
      mvs_pkg::MODE_PATTERN: begin
        back = eff_len - mvs_pkg::FILL_W'(1);
        cond = (fill_nxt >= eff_len) && pat_ok;
      end
      default: begin
        back = '0;
        cond = 1'b0;
      end
    endcase
  end

  assign hit = cond && !faulted_nxt;

  // Saturating page count
  always_comb begin
    if (hit && (count_r != mvs_pkg::COUNT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  // Record for the back end
  always_comb begin
    q_rec.has_match   = hit;
    q_rec.match_addr  = in_byte_address - mvs_pkg::ADDR_BITS'(back);
    q_rec.has_status  = in_page_end;
    q_rec.status_kind = faulted_nxt ? mvs_pkg::KIND_ABORT : mvs_pkg::KIND_DONE;
    q_rec.count       = count_nxt;
  end

  assign q_push = accept && (hit || in_page_end);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mvs_pkg::MODE_BYTE;
      value_r  <= '0;
      plen_r   <= mvs_pkg::PLEN_W'(1);
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mvs_pkg::CFG_MODE:     mode_r   <= mvs_pkg::mode_t'(cfg_wdata[1:0]);
        mvs_pkg::CFG_VALUE:    value_r  <= cfg_wdata[mvs_pkg::VALUE_W-1:0];
        mvs_pkg::CFG_PLEN:     plen_r   <= cfg_wdata[mvs_pkg::PLEN_W-1:0];
        mvs_pkg::CFG_PAT_LOW:  pat_lo_r <= cfg_wdata;
        mvs_pkg::CFG_PAT_HIGH: pat_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Page state; cleared at page end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mvs_pkg::PATTERN_MAX; i++) begin
        win_r[i] <= '0;
      end
      fill_r    <= '0;
      faulted_r <= 1'b0;
      count_r   <= '0;
    end else if (accept) begin
      if (in_page_end) begin
        for (int i = 0; i < mvs_pkg::PATTERN_MAX; i++) begin
          win_r[i] <= '0;
        end
        fill_r    <= '0;
        faulted_r <= 1'b0;
        count_r   <= '0;
      end else begin
        for (int i = 0; i < mvs_pkg::PATTERN_MAX; i++) begin
          win_r[i] <= win_nxt[i];
        end
        fill_r    <= fill_nxt;
        faulted_r <= faulted_nxt;
        count_r   <= count_nxt;
      end
    end
  end

endmodule

### sv/mvs_queue.sv
// Short record queue between front and back end of the scanner.
// Depends on mvs_pkg.
`timescale 1ns / 1ps

module mvs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mvs_pkg::rec_t   push_rec,
  output logic            full,
  input  logic            pop,
  output mvs_pkg::qhead_t head
);

  mvs_pkg::rec_t              mem_r [mvs_pkg::QUEUE_DEPTH];
  logic [mvs_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mvs_pkg::QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == mvs_pkg::QCNT_W'(mvs_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.rec   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mvs_pkg::QCNT_W'(mvs_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### sv/mvs_back.sv
// Back end of the scanner: turns queue records into output beats
// (match, then page status) through a registered output stage.
// Depends on mvs_pkg.
`timescale 1ns / 1ps

module mvs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mvs_pkg::qhead_t               q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_result_kind,
  output logic [mvs_pkg::ADDR_BITS-1:0] out_match_address,
  output logic [mvs_pkg::COUNT_W-1:0]   out_page_match_count,
  output logic                          out_last
);

  logic                          out_valid_r;
  mvs_pkg::kind_t                kind_r;
  logic [mvs_pkg::ADDR_BITS-1:0] addr_r;
  logic [mvs_pkg::COUNT_W-1:0]   count_r;
  logic                          last_r;
  logic                          phase_r;  // match beat of head already sent

  logic load;
  logic emit_match;
  logic emit_last;

  assign load       = !out_valid_r || !out_stall;
  assign emit_match = q_head.rec.has_match && !phase_r;
  assign emit_last  = !emit_match || !q_head.rec.has_status;
  assign q_pop      = load && q_head.valid && emit_last;

  assign out_valid            = out_valid_r;
  assign out_result_kind      = kind_r;
  assign out_match_address    = addr_r;
  assign out_page_match_count = count_r;
  assign out_last             = last_r;

  // Output register and beat sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= q_head.valid;
      if (q_head.valid) begin
        last_r  <= emit_last;
        phase_r <= !emit_last;
        if (emit_match) begin
          kind_r  <= mvs_pkg::KIND_MATCH;
          addr_r  <= q_head.rec.match_addr;
          count_r <= '0;
        end else begin
          kind_r  <= q_head.rec.status_kind;
          addr_r  <= '0;
          count_r <= q_head.rec.count;
        end
      end
    end
  end

  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (q_head.valid && q_head.rec.has_match && q_head.rec.has_status))
    else $error("status phase without a two-beat record at head");

  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !last_r) |=>
      (out_valid_r && (kind_r != mvs_pkg::KIND_MATCH) && last_r))
    else $error("match beat without last not followed by page status");

  a_record_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_head.valid && !q_head.rec.has_match) |-> q_head.rec.has_status)
    else $error("empty record in queue");

endmodule

### sv/memory_value_scan.sv
// Top level of the memory value scanner: front end, record queue, back end.
// Depends on mvs_pkg, mvs_front, mvs_queue, mvs_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one memory byte per beat with its
//   address, a page-end mark and a fault flag. A beat is taken one per cycle
//   while the four-entry record queue has room.
//   Output channel (out_valid / out_stall): match beats (start address) and
//   one page status beat per page end (completed or aborted, with the page's
//   match count). out_last marks the final beat caused by one input byte.
//   Config port (cfg_we / cfg_index / cfg_wdata): write only, while idle.
// Path: a result is written into the record queue when its byte is taken,
//   then loaded into the output register when that register is free.
// Throughput: one byte per cycle while the queue has room; a byte that both
//   matches and ends a page needs two output beats, so the single output
//   register sets the peak rate at one beat per cycle.
// Reset (rst_n low, synchronous) empties the queue and output, clears the
//   window and page state and restores register defaults.
// Stall: out_stall holds the output beat; the queue fills and then in_stall
//   rises until the output drains.
`timescale 1ns / 1ps

module memory_value_scan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte_value,
  input  logic [mvs_pkg::ADDR_BITS-1:0]        in_byte_address,
  input  logic                                 in_page_end,
  input  logic                                 in_access_fault,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_result_kind,
  output logic [mvs_pkg::ADDR_BITS-1:0]        out_match_address,
  output logic [mvs_pkg::COUNT_W-1:0]          out_page_match_count,
  output logic                                 out_last
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  mvs_pkg::rec_t   q_rec;
  mvs_pkg::qhead_t q_head;

  mvs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_byte_address (in_byte_address),
    .in_page_end     (in_page_end),
    .in_access_fault (in_access_fault),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_rec           (q_rec)
  );

  mvs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  mvs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_match_address    (out_match_address),
    .out_page_match_count (out_page_match_count),
    .out_last             (out_last)
  );

endmodule

### sim/memory_value_scan_tb.sv
// Self-checking testbench for memory_value_scan: directed and random byte streams,
// with a scoreboard that predicts match and page status beats in order.
// Depends on mvs_pkg and memory_value_scan.
`timescale 1ns / 1ps

module memory_value_scan_tb;

  localparam int PHASES         = 16;
  localparam int PHASE_ITEMS    = 66;
  localparam int QUIET_PHASES   = 3;
  localparam int PAGE_BUF       = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  // Index past the last register; writes there must be ignored
  localparam logic [mvs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    mvs_pkg::kind_t                kind;
    logic [mvs_pkg::ADDR_BITS-1:0] addr;
    logic [mvs_pkg::COUNT_W-1:0]   count;
    logic                          last;
  } scan_beat_t;

  // Scanner prediction and result checking
  class scan_scoreboard;
    mvs_pkg::mode_t                  mode;
    logic [mvs_pkg::VALUE_W-1:0]     value;
    logic [mvs_pkg::PLEN_W-1:0]      plen;
    logic [mvs_pkg::PATWORD_W-1:0]   pat_lo;
    logic [mvs_pkg::PATWORD_W-1:0]   pat_hi;
    logic [7:0]                      win [mvs_pkg::PATTERN_MAX];
    int unsigned                     fill;
    bit                              faulted;
    logic [mvs_pkg::COUNT_W-1:0]     page_hits;
    scan_beat_t                      expected_beats [$];
    int                              errors;

    function new();
      mode    = mvs_pkg::MODE_BYTE;
      value   = '0;
      plen    = 5'd1;
      pat_lo  = '0;
      pat_hi  = '0;
      errors  = 0;
      clear_page();
    endfunction

    function void clear_page();
      foreach (win[i]) win[i] = 8'h00;
      fill      = 0;
      faulted   = 1'b0;
      page_hits = '0;
    endfunction

    function void flag(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void set_reg(logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                          logic [mvs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mvs_pkg::CFG_MODE:     mode   = mvs_pkg::mode_t'(data[1:0]);
        mvs_pkg::CFG_VALUE:    value  = data[mvs_pkg::VALUE_W-1:0];
        mvs_pkg::CFG_PLEN:     plen   = data[mvs_pkg::PLEN_W-1:0];
        mvs_pkg::CFG_PAT_LOW:  pat_lo = data;
        mvs_pkg::CFG_PAT_HIGH: pat_hi = data;
        default: ;
      endcase
    endfunction

    // Zero length acts as one, lengths past the window saturate
    function int unsigned pattern_len();
      if (plen == 0) return 1;
      if (plen > mvs_pkg::PATTERN_MAX) return mvs_pkg::PATTERN_MAX;
      return plen;
    endfunction

    function logic [7:0] pattern_byte(int unsigned j);
      return (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // One accepted byte: shift the window, test for a match, close the page
    function void note_byte(logic [7:0] data, logic [mvs_pkg::ADDR_BITS-1:0] addr,
                            logic page_end, logic fault);
      int unsigned back;
      int unsigned len;
      int unsigned i;
      bit          hit;
      scan_beat_t  b;
      for (i = mvs_pkg::PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = fault ? 8'h00 : data;
      if (fill < mvs_pkg::PATTERN_MAX) fill++;
      if (fault) faulted = 1'b1;
      hit  = 1'b0;
      back = 0;
      if (!faulted) begin
        case (mode)
          mvs_pkg::MODE_BYTE: hit = (win[0] == value[7:0]);
          mvs_pkg::MODE_HALF: begin
            back = 1;
            hit  = addr[0] && fill >= 2 && ({win[0], win[1]} == value[15:0]);
          end
          mvs_pkg::MODE_WORD: begin
            back = 3;
            hit  = (addr[1:0] == 2'b11) && fill >= 4 &&
                   ({win[0], win[1], win[2], win[3]} == value);
          end
          default: begin
            len  = pattern_len();
            back = len - 1;
            hit  = (fill >= len);
            for (i = 0; i < len; i++)
              if (win[len-1-i] != pattern_byte(i)) hit = 1'b0;
          end
        endcase
      end
      if (hit) begin
        b.kind  = mvs_pkg::KIND_MATCH;
        b.addr  = addr - mvs_pkg::ADDR_BITS'(back);
        b.count = '0;
        b.last  = !page_end;
        expected_beats.push_back(b);
        if (page_hits != mvs_pkg::COUNT_MAX) page_hits++;
      end
      if (page_end) begin
        b.kind  = faulted ? mvs_pkg::KIND_ABORT : mvs_pkg::KIND_DONE;
        b.addr  = '0;
        b.count = page_hits;
        b.last  = 1'b1;
        expected_beats.push_back(b);
        clear_page();
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [mvs_pkg::ADDR_BITS-1:0] addr,
                             logic [mvs_pkg::COUNT_W-1:0] count, logic last);
      scan_beat_t b;
      if (expected_beats.size() == 0) begin
        flag($sformatf("unexpected beat: expected none, actual kind %0d addr %h count %0d",
                       kind, addr, count));
        return;
      end
      b = expected_beats.pop_front();
      if (kind !== b.kind)
        flag($sformatf("result_kind expected %0d actual %0d", b.kind, kind));
      if (addr !== b.addr)
        flag($sformatf("match_address expected %h actual %h", b.addr, addr));
      if (count !== b.count)
        flag($sformatf("page_match_count expected %0d actual %0d", b.count, count));
      if (last !== b.last)
        flag($sformatf("last expected %0b actual %0b", b.last, last));
    endfunction

    function void flush_leftovers();
      scan_beat_t b;
      while (expected_beats.size() != 0) begin
        b = expected_beats.pop_front();
        flag($sformatf("missing beat: expected kind %0d addr %h count %0d, actual none",
                       b.kind, b.addr, b.count));
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mvs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mvs_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_byte_value;
  logic [mvs_pkg::ADDR_BITS-1:0]  in_byte_address;
  logic                           in_page_end;
  logic                           in_access_fault;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_result_kind;
  logic [mvs_pkg::ADDR_BITS-1:0]  out_match_address;
  logic [mvs_pkg::COUNT_W-1:0]    out_page_match_count;
  logic                           out_last;

  scan_scoreboard sb;
  int             gap_pct   = 20;
  int             stall_pct = 20;
  int             stall_left = 0;
  int             stuck_cycles = 0;
  int             items_sent = 0;
  logic [7:0]     target [mvs_pkg::PATTERN_MAX];
  int             target_len;
  int             target_align;

  memory_value_scan i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_value        (in_byte_value),
    .in_byte_address      (in_byte_address),
    .in_page_end          (in_page_end),
    .in_access_fault      (in_access_fault),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_match_address    (out_match_address),
    .out_page_match_count (out_page_match_count),
    .out_last             (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output backpressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Beat monitor: values sampled before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_beat(out_result_kind, out_match_address, out_page_match_count, out_last);
      if (in_valid && !in_stall)
        sb.note_byte(in_byte_value, in_byte_address, in_page_end, in_access_fault);
    end
  end

  // Watchdog: too long with no beat on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] data, logic [mvs_pkg::ADDR_BITS-1:0] addr,
                           logic page_end, logic fault);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_value   <= data;
    in_byte_address <= addr;
    in_page_end     <= page_end;
    in_access_fault <= fault;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // Drop valid and let every expected beat drain, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [mvs_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(mvs_pkg::mode_t mode, logic [mvs_pkg::VALUE_W-1:0] val,
                           logic [mvs_pkg::PLEN_W-1:0] len_code,
                           logic [mvs_pkg::PATWORD_W-1:0] lo,
                           logic [mvs_pkg::PATWORD_W-1:0] hi);
    write_reg(mvs_pkg::CFG_MODE, mvs_pkg::CFG_DATA_W'(mode));
    write_reg(mvs_pkg::CFG_VALUE, mvs_pkg::CFG_DATA_W'(val));
    write_reg(mvs_pkg::CFG_PLEN, mvs_pkg::CFG_DATA_W'(len_code));
    write_reg(mvs_pkg::CFG_PAT_LOW, lo);
    write_reg(mvs_pkg::CFG_PAT_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // Settings per phase, with the register extremes on fixed phases
  task automatic setup_phase(int p);
    logic [mvs_pkg::VALUE_W-1:0]   val;
    logic [mvs_pkg::PLEN_W-1:0]    len_code;
    logic [mvs_pkg::PATWORD_W-1:0] lo;
    logic [mvs_pkg::PATWORD_W-1:0] hi;
    mvs_pkg::mode_t                mode;
    int                            j;
    mode     = mvs_pkg::mode_t'(2'(p % 4));
    val      = $urandom();
    len_code = 5'($urandom_range(0, 31));
    lo       = {$urandom(), $urandom()};
    hi       = {$urandom(), $urandom()};
    if (p == 0 || p == 5 || p == 6) val = '0;
    if (p == 1 || p == 2) val = '1;
    case (p)
      3:  len_code = 5'd16;
      7:  begin
        len_code = 5'd31;
        lo       = '1;
        hi       = '1;
      end
      11: begin
        len_code = 5'd1;
        lo       = '0;
        hi       = '0;
      end
      15: len_code = 5'($urandom_range(2, 15));
      default: ;
    endcase
    configure(mode, val, len_code, lo, hi);
    case (mode)
      mvs_pkg::MODE_BYTE: begin
        target_len   = 1;
        target_align = 1;
      end
      mvs_pkg::MODE_HALF: begin
        target_len   = 2;
        target_align = 2;
      end
      mvs_pkg::MODE_WORD: begin
        target_len   = 4;
        target_align = 4;
      end
      default: begin
        target_len   = sb.pattern_len();
        target_align = 1;
      end
    endcase
    for (j = 0; j < target_len; j++)
      target[j] = (mode == mvs_pkg::MODE_PATTERN) ? sb.pattern_byte(j) : val[8*j +: 8];
    if (p >= PHASES - QUIET_PHASES) begin
      gap_pct   = 0;
      stall_pct = 0;
    end else begin
      gap_pct   = 20 * $urandom_range(0, 2);
      stall_pct = 20 * $urandom_range(0, 2);
    end
  endtask

  // One page: bytes biased toward the target, with planted aligned copies,
  // sometimes a fault, sometimes scrambled addresses
  task automatic run_page();
    logic [7:0]                    buf_bytes [PAGE_BUF];
    logic [63:0]                   r;
    logic [mvs_pkg::ADDR_BITS-1:0] base;
    logic [mvs_pkg::ADDR_BITS-1:0] addr;
    int                            len;
    int                            fault_at;
    int                            o;
    int                            k;
    bit                            scramble;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, PAGE_BUF) : $urandom_range(1, 40);
    r    = {$urandom(), $urandom()};
    base = r[mvs_pkg::ADDR_BITS-1:0];
    // near the top of the address space so pages wrap through zero
    if ($urandom_range(0, 7) == 0) base = '1 - mvs_pkg::ADDR_BITS'($urandom_range(0, 63));
    for (k = 0; k < len; k++)
      buf_bytes[k] = $urandom_range(0, 1) ? target[$urandom_range(0, target_len - 1)]
                                          : 8'($urandom_range(0, 255));
    if (len >= target_len) begin
      repeat ($urandom_range(0, 3)) begin
        o = $urandom_range(0, len - target_len);
        o = o - (int'(base[3:0]) + o) % target_align;
        if (o >= 0)
          for (k = 0; k < target_len; k++) buf_bytes[o+k] = target[k];
      end
    end
    fault_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
    scramble = ($urandom_range(0, 11) == 0);
    for (k = 0; k < len; k++) begin
      r    = {$urandom(), $urandom()};
      addr = scramble ? r[mvs_pkg::ADDR_BITS-1:0] : base + mvs_pkg::ADDR_BITS'(k);
      send_byte(buf_bytes[k], addr, k == len - 1, k == fault_at);
    end
  endtask

  initial begin
    int p;
    int phase_start;
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_byte_value   <= '0;
    in_byte_address <= '0;
    in_page_end     <= 1'b0;
    in_access_fault <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: byte mode, value zero; fault aborts the page
    send_byte(8'h00, 48'h0, 1'b0, 1'b0);
    send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_byte(8'h5C, 48'h2, 1'b0, 1'b1);
    send_byte(8'h00, 48'h3, 1'b1, 1'b0);
    wait_idle();

    // Write to a missing register index changes nothing
    write_reg(CFG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_byte(8'h00, 48'h10, 1'b1, 1'b0);
    wait_idle();

    // Aligned halfword, first byte of the page alone cannot match
    configure(mvs_pkg::MODE_HALF, 32'h0000_BEEF, 5'd1, '0, '0);
    send_byte(8'hBE, 48'h21, 1'b0, 1'b0);
    send_byte(8'hEF, 48'h22, 1'b0, 1'b0);
    send_byte(8'hBE, 48'h23, 1'b1, 1'b0);
    wait_idle();

    // Aligned word at the very top of the address space
    configure(mvs_pkg::MODE_WORD, 32'hDEAD_BEEF, 5'd1, '0, '0);
    send_byte(8'hEF, 48'hFFFF_FFFF_FFFC, 1'b0, 1'b0);
    send_byte(8'hBE, 48'hFFFF_FFFF_FFFD, 1'b0, 1'b0);
    send_byte(8'hAD, 48'hFFFF_FFFF_FFFE, 1'b0, 1'b0);
    send_byte(8'hDE, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
    wait_idle();

    // Pattern length zero acts as one; fault on the page-end byte
    configure(mvs_pkg::MODE_PATTERN, 32'h0, 5'd0, 64'h77, '0);
    send_byte(8'h77, 48'h40, 1'b0, 1'b0);
    send_byte(8'h77, 48'h41, 1'b1, 1'b1);
    wait_idle();

    // Pattern across the address wrap: start lies below zero
    configure(mvs_pkg::MODE_PATTERN, 32'h0, 5'd4, 64'h4433_2211, '0);
    send_byte(8'h11, 48'hFFFF_FFFF_FFFE, 1'b0, 1'b0);
    send_byte(8'h22, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_byte(8'h33, 48'h0, 1'b0, 1'b0);
    send_byte(8'h44, 48'h1, 1'b1, 1'b0);
    wait_idle();

    // Random phases over all modes and register extremes
    for (p = 0; p < PHASES; p++) begin
      setup_phase(p);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_page();
      wait_idle();
    end

    sb.flush_leftovers();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### memory_value_scan.f
sv/mvs_pkg.sv
sv/mvs_front.sv
sv/mvs_queue.sv
sv/mvs_back.sv
sv/memory_value_scan.sv
sim/memory_value_scan_tb.sv
